>>> hdl/ttbd_pkg.sv
package ttbd_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam int FRAC_W   = 16;
    localparam int SAMPLE_W = 16;
    localparam int NUM_CH   = 4;
    localparam int NUM_TAPS = 13;
    localparam int TAP_W    = 4;
    localparam int COORD_W  = 11;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

    localparam logic CMD_WRITE   = 1'b0;
    localparam logic CMD_COMPUTE = 1'b1;

    // x offset of each tap in output pixels
    function automatic logic signed [2:0] tap_off_x(input logic [TAP_W-1:0] k);
        logic signed [2:0] r;
        case (k)
            4'd0, 4'd2:        r = -3'sd1;
            4'd1, 4'd3:        r = 3'sd1;
            4'd4, 4'd7, 4'd10: r = -3'sd2;
            4'd6, 4'd9, 4'd12: r = 3'sd2;
            default:           r = 3'sd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [2:0] tap_off_y(input logic [TAP_W-1:0] k);
        logic signed [2:0] r;
        case (k)
            4'd0, 4'd1:          r = 3'sd1;
            4'd2, 4'd3:          r = -3'sd1;
            4'd4, 4'd5, 4'd6:    r = 3'sd2;
            4'd10, 4'd11, 4'd12: r = -3'sd2;
            default:             r = 3'sd0;
        endcase
        return r;
    endfunction

    // diagonal taps weigh 9/72, the rest 4/72
    function automatic logic tap_is_diag(input logic [TAP_W-1:0] k);
        return k < 4'd4;
    endfunction

endpackage

>>> hdl/thirteen_tap_bilinear_downsample_core.sv
// Write request: stored at the transfer edge, no result.
// Compute request: 13 taps, each one Q16 position per axis from a bit-serial
// divider (axes in parallel) and four frame reads.
// One item is in flight at a time; a finished result waits in the output register.
// Reset loads width 256, height 256, four channels; the frame store is not cleared.
module thirteen_tap_bilinear_downsample_core #(
    parameter int MAX_WIDTH  = ttbd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ttbd_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ttbd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ttbd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_cmd,
    input  logic [7:0]                          i_col,
    input  logic [7:0]                          i_row,
    input  logic [15:0]                         i_value_0,
    input  logic [15:0]                         i_value_1,
    input  logic [15:0]                         i_value_2,
    input  logic [15:0]                         i_value_3,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [15:0]                         o_result_0,
    output logic [15:0]                         o_result_1,
    output logic [15:0]                         o_result_2,
    output logic [15:0]                         o_result_3
);
    import ttbd_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int XSW = $clog2(MAX_WIDTH + 1);
    localparam int YSW = $clog2(MAX_HEIGHT + 1);
    localparam int WGT_W = FRAC_W + 1;
    localparam int CWT_W = 2 * WGT_W;
    localparam int PROD_W = SAMPLE_W + CWT_W;
    localparam int ACC_W = 56;
    localparam int T_W = 20;
    localparam int MUL_W = 40;
    localparam logic [T_W-1:0] T_SAT = T_W'(9 * 65536);
    localparam logic [T_W-1:0] DIV9_MUL = T_W'(932068);
    localparam logic [WGT_W-1:0] ONE_Q16 = WGT_W'(65536);

    typedef enum logic [2:0] {
        S_IDLE, S_TAP, S_WAIT, S_RD, S_MUL, S_ACC, S_FIN
    } t_state;

    t_state r_state;

    logic [CFG_DATA_W-1:0] r_src_width;
    logic [CFG_DATA_W-1:0] r_src_height;
    logic [2:0]            r_channel_count;

    logic [63:0] r_mem [2**(XW+YW)];
    logic [63:0] r_rd_data;

    logic [7:0]        r_col;
    logic [7:0]        r_row;
    logic [2:0]        r_nch;
    logic [TAP_W-1:0]  r_tap;
    logic [1:0]        r_corner;
    logic [CWT_W-1:0]  r_cw;
    logic [PROD_W-1:0] r_prod [NUM_CH];
    logic [ACC_W-1:0]  r_acc [NUM_CH];
    logic              r_out_valid;
    logic [15:0]       r_result [NUM_CH];

    logic [31:0]   w32, h32, col32, row32;
    logic [XSW-1:0] w_eff;
    logic [YSW-1:0] h_eff;
    logic [2:0]    nch_eff;
    logic          in_accept;
    logic          wr_ok;
    logic          div_start;
    logic signed [COORD_W-1:0] nx, ny;
    logic signed [2:0] offx, offy;
    logic          x_busy, y_busy;
    logic [XW-1:0] x_lo, x_hi;
    logic [YW-1:0] y_lo, y_hi;
    logic [FRAC_W-1:0] x_frac, y_frac;
    logic [WGT_W-1:0]  wx, wy;
    logic [XW-1:0] rd_x;
    logic [YW-1:0] rd_y;
    logic          out_free;
    logic [T_W-1:0]   t_val [NUM_CH];
    logic [MUL_W-1:0] q_mul [NUM_CH];
    logic [15:0]      q_res [NUM_CH];

    always_comb begin
        w32 = 32'(r_src_width);
        h32 = 32'(r_src_height);
        if (w32 < 32'd2) w32 = 32'd2;
        if (w32 > 32'(MAX_WIDTH)) w32 = 32'(MAX_WIDTH);
        if (h32 < 32'd2) h32 = 32'd2;
        if (h32 > 32'(MAX_HEIGHT)) h32 = 32'(MAX_HEIGHT);
        w_eff = w32[XSW-1:0];
        h_eff = h32[YSW-1:0];
        if (r_channel_count == 3'd0) begin
            nch_eff = 3'd1;
        end else if (r_channel_count > 3'd4) begin
            nch_eff = 3'd4;
        end else begin
            nch_eff = r_channel_count;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;
    assign col32 = 32'(i_col);
    assign row32 = 32'(i_row);
    assign wr_ok = (col32 < 32'(MAX_WIDTH)) && (row32 < 32'(MAX_HEIGHT));

    assign offx = tap_off_x(r_tap);
    assign offy = tap_off_y(r_tap);
    assign nx = $signed({2'b00, r_col, 1'b1}) + $signed({{7{offx[2]}}, offx, 1'b0});
    assign ny = $signed({2'b00, r_row, 1'b1}) + $signed({{7{offy[2]}}, offy, 1'b0});
    assign div_start = (r_state == S_TAP);

    ttbd_axis_pos #(.MAX_SIZE(MAX_WIDTH)) u_xpos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_n     (nx),
        .i_size  (w_eff),
        .o_busy  (x_busy),
        .o_lo    (x_lo),
        .o_hi    (x_hi),
        .o_frac  (x_frac)
    );

    ttbd_axis_pos #(.MAX_SIZE(MAX_HEIGHT)) u_ypos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_n     (ny),
        .i_size  (h_eff),
        .o_busy  (y_busy),
        .o_lo    (y_lo),
        .o_hi    (y_hi),
        .o_frac  (y_frac)
    );

    // corner 0..3: bit 0 picks the right column, bit 1 the lower row
    assign rd_x = r_corner[0] ? x_hi : x_lo;
    assign rd_y = r_corner[1] ? y_hi : y_lo;
    assign wx = r_corner[0] ? WGT_W'(x_frac) : ONE_Q16 - WGT_W'(x_frac);
    assign wy = r_corner[1] ? WGT_W'(y_frac) : ONE_Q16 - WGT_W'(y_frac);

    always_ff @(posedge i_clk) begin
        if (in_accept && i_cmd == CMD_WRITE && wr_ok) begin
            r_mem[{row32[YW-1:0], col32[XW-1:0]}] <= {i_value_3, i_value_2, i_value_1, i_value_0};
        end
        if (r_state == S_RD) begin
            r_rd_data <= r_mem[{rd_y, rd_x}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width     <= CFG_DATA_W'(256);
            r_src_height    <= CFG_DATA_W'(256);
            r_channel_count <= 3'd4;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SRC_WIDTH:     r_src_width <= i_cfg_data;
                REG_SRC_HEIGHT:    r_src_height <= i_cfg_data;
                REG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            t_val[c] = r_acc[c][ACC_W-2 -: T_W];
            q_mul[c] = MUL_W'(t_val[c]) * MUL_W'(DIV9_MUL);
            if (32'(c) >= 32'(r_nch)) begin
                q_res[c] = '0;
            end else if (t_val[c] >= T_SAT) begin
                q_res[c] = 16'hFFFF;
            end else begin
                q_res[c] = q_mul[c][38:23];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_tap       <= '0;
            r_corner    <= '0;
        end else begin
            // drop the transferred result unless a new one replaces it
            if (r_out_valid && i_out_ready && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept && i_cmd == CMD_COMPUTE) begin
                        r_col    <= i_col;
                        r_row    <= i_row;
                        r_nch    <= nch_eff;
                        r_tap    <= '0;
                        r_corner <= '0;
                        for (int c = 0; c < NUM_CH; c++) r_acc[c] <= '0;
                        r_state  <= S_TAP;
                    end
                end
                S_TAP: r_state <= S_WAIT;
                S_WAIT: begin
                    if (!x_busy && !y_busy) r_state <= S_RD;
                end
                S_RD: begin
                    r_cw    <= wx * wy;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    for (int c = 0; c < NUM_CH; c++) begin
                        r_prod[c] <= r_rd_data[16*c +: 16] * r_cw;
                    end
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    for (int c = 0; c < NUM_CH; c++) begin
                        if (tap_is_diag(r_tap)) begin
                            r_acc[c] <= r_acc[c] + (ACC_W'(r_prod[c]) << 3) + ACC_W'(r_prod[c]);
                        end else begin
                            r_acc[c] <= r_acc[c] + (ACC_W'(r_prod[c]) << 2);
                        end
                    end
                    r_corner <= r_corner + 2'd1;
                    if (r_corner != 2'd3) begin
                        r_state <= S_RD;
                    end else if (r_tap == TAP_W'(NUM_TAPS - 1)) begin
                        r_state <= S_FIN;
                    end else begin
                        r_tap   <= r_tap + TAP_W'(1);
                        r_state <= S_TAP;
                    end
                end
                S_FIN: begin
                    // hold until the output register is free
                    if (out_free) begin
                        for (int c = 0; c < NUM_CH; c++) r_result[c] <= q_res[c];
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result_0  = r_result[0];
    assign o_result_1  = r_result[1];
    assign o_result_2  = r_result[2];
    assign o_result_3  = r_result[3];

    a_compute_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_cmd == CMD_COMPUTE) |=> r_state != S_IDLE)
        else $error("compute transfer did not start work");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_FIN) |-> (!x_busy && !y_busy))
        else $error("position divider busy outside a tap");

    a_unused_ch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_out_valid) && r_nch < 3'd4) |-> o_result_3 == '0)
        else $error("unused channel not zero");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> ($stable(o_result_0) && $stable(o_result_3)))
        else $error("pending result overwritten");

endmodule

>>> hdl/ttbd_axis_pos.sv
module ttbd_axis_pos #(
    parameter int MAX_SIZE = ttbd_pkg::DEF_MAX_WIDTH,
    parameter int IW = $clog2(MAX_SIZE),
    parameter int SW = $clog2(MAX_SIZE + 1)
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic signed [ttbd_pkg::COORD_W-1:0]    i_n,
    input  logic [SW-1:0]                          i_size,
    output logic                                   o_busy,
    output logic [IW-1:0]                          o_lo,
    output logic [IW-1:0]                          o_hi,
    output logic [ttbd_pkg::FRAC_W-1:0]            o_frac
);
    import ttbd_pkg::*;

    localparam int QW = IW + FRAC_W;
    localparam int DW = SW + IW + FRAC_W;
    localparam int CW = $clog2(QW + 1);

    logic [SW-1:0]    r_rem;
    logic [QW-1:0]    r_low;
    logic [SW-1:0]    r_div;
    logic [IW-1:0]    r_last;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;

    logic [31:0]      m32;
    logic [31:0]      twice32;
    logic [SW-1:0]    twice;
    logic [IW-1:0]    last;
    logic [DW-1:0]    dividend;
    logic [SW:0]      trial;
    logic             qbit;
    logic [IW-1:0]    x0;

    always_comb begin
        twice   = {i_size[SW-1:1], 1'b0};
        twice32 = 32'(twice);
        m32     = i_n[COORD_W-1] ? 32'd0 : 32'(i_n);
        if (m32 > twice32) begin
            m32 = twice32;
        end
        last     = IW'(i_size - SW'(1));
        dividend = {(SW + IW)'(m32[SW-1:0] * last), {FRAC_W{1'b0}}};
        trial    = {r_rem, r_low[QW-1]};
        qbit     = trial >= {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(QW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // restoring division, one quotient bit a cycle; quotient shifts into r_low
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= dividend[DW-1:QW];
            r_low  <= dividend[QW-1:0];
            r_div  <= twice;
            r_last <= last;
        end else if (r_busy) begin
            r_rem <= qbit ? SW'(trial - {1'b0, r_div}) : trial[SW-1:0];
            r_low <= {r_low[QW-2:0], qbit};
        end
    end

    assign x0     = r_low[QW-1:FRAC_W];
    assign o_busy = r_busy;
    assign o_lo   = (x0 > r_last) ? r_last : x0;
    assign o_hi   = (x0 < r_last) ? x0 + IW'(1) : r_last;
    assign o_frac = r_low[FRAC_W-1:0];

endmodule
